// ===== src/touch_drum_trigger_voice_table_macros.svh =====
// Assertion macros for the drum trigger block.
// Included by the top level; depends on nothing else.
`ifndef TOUCH_DRUM_TRIGGER_VOICE_TABLE_MACROS_SVH
`define TOUCH_DRUM_TRIGGER_VOICE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tdt_pkg.sv =====
// Shared types, codes and constants for the drum trigger block.
// Used by every module of the block; depends on nothing.
package tdt_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int DEF_VOICE_SLOTS  = 8;
    localparam int DEF_FINGER_COUNT = 5;
    localparam int DEF_PAD_COUNT    = 8;

    // Results per input item, and the width of their counter.
    localparam int MAX_RESULTS = 8;
    localparam int RES_W       = 3;

    localparam logic [31:0] HOLD_TICKS       = 32'd250;
    localparam logic [6:0]  DEFAULT_VELOCITY = 7'd110;
    localparam logic [6:0]  VELOCITY_MAX     = 7'd127;

    // Pad numbers carry a code for "no pad".
    localparam int          PAD_IDX_W = 4;
    localparam logic [3:0]  NO_PAD    = 4'd15;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 55;

    // Command codes.
    localparam logic [2:0] CMD_DOWN    = 3'd0;
    localparam logic [2:0] CMD_MOVE    = 3'd1;
    localparam logic [2:0] CMD_UP      = 3'd2;
    localparam logic [2:0] CMD_DIRECT  = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;
    localparam logic [2:0] CMD_RELEASE = 3'd5;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [2:0]         finger;
        logic signed [15:0] touch_x;
        logic signed [15:0] touch_y;
        logic [7:0]         pressure;
        logic [6:0]         direct_note;
    } t_in;

    typedef struct packed {
        logic       note_on;
        logic [6:0] note_number;
        logic [6:0] velocity;
        logic       last;
    } t_out;

    // One pad register, laid out as written over the configuration port.
    typedef struct packed {
        logic [6:0]         note;
        logic [15:0]        radius;
        logic signed [15:0] cy;
        logic signed [15:0] cx;
    } t_pad;

    // Contents of one voice cell.
    typedef struct packed {
        logic [6:0]  note;
        logic [31:0] rtime;
    } t_voice;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    // Answer of the hit test unit.
    typedef struct packed {
        logic                 done;
        logic [PAD_IDX_W-1:0] pad;
        logic [6:0]           note;
    } t_hit_rsp;

    typedef enum logic [1:0] {
        HU_IDLE,
        HU_MUL,
        HU_CMP
    } t_hit_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_STEAL,
        ST_PLAY,
        ST_EXPIRE,
        ST_FLUSH
    } t_state;

endpackage

// ===== src/tdt_voice_cell.sv =====
// One cell of the held-note chain: a note and its release time.
// Depends on tdt_pkg for the cell data and control types.
module tdt_voice_cell (
    input  logic                i_clk,
    input  tdt_pkg::t_cell_ctrl i_ctrl,
    input  tdt_pkg::t_voice     i_next,
    input  tdt_pkg::t_voice     i_load,
    input  logic [31:0]         i_tick,
    output tdt_pkg::t_voice     o_voice,
    output logic                o_due
);
    import tdt_pkg::*;

    t_voice      r_voice;
    logic [31:0] w_diff;

    // Take the neighbour's entry when the chain closes up, or a new note.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_voice <= i_next;
        end else if (i_ctrl.load) begin
            r_voice <= i_load;
        end
    end

    // The note is due once the wrapped difference is not negative.
    assign w_diff  = i_tick - r_voice.rtime;
    assign o_due   = ~w_diff[31];
    assign o_voice = r_voice;

endmodule

// ===== src/tdt_hit_unit.sv =====
// Hit test sequencer: walks the pads one at a time, first hit wins.
// Depends on tdt_pkg for the pad, response and state types.
module tdt_hit_unit #(
    parameter int PAD_COUNT = tdt_pkg::DEF_PAD_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  tdt_pkg::t_pad      i_pads [PAD_COUNT],
    output tdt_pkg::t_hit_rsp  o_rsp
);
    import tdt_pkg::*;

    localparam int PIW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    t_hit_state         r_state;
    t_hit_state         n_state;
    logic [PIW-1:0]     r_idx;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [31:0]        r_sqx;
    logic [31:0]        r_sqy;
    logic [31:0]        r_sqr;

    t_pad               w_pad;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic [15:0]        w_ax;
    logic [15:0]        w_ay;
    logic [31:0]        w_sqx;
    logic [31:0]        w_sqy;
    logic [31:0]        w_sqr;
    logic [32:0]        w_dist;
    logic               w_hit;
    logic               w_last_pad;

    // Offsets and their magnitudes for the pad under test.
    assign w_pad = i_pads[r_idx];
    assign w_dx  = {r_x[15], r_x} - {w_pad.cx[15], w_pad.cx};
    assign w_dy  = {r_y[15], r_y} - {w_pad.cy[15], w_pad.cy};
    assign w_ax  = w_dx[16] ? 16'(-w_dx) : w_dx[15:0];
    assign w_ay  = w_dy[16] ? 16'(-w_dy) : w_dy[15:0];
    assign w_sqx = 32'(w_ax) * 32'(w_ax);
    assign w_sqy = 32'(w_ay) * 32'(w_ay);
    assign w_sqr = 32'(w_pad.radius) * 32'(w_pad.radius);

    // Compare the registered squares.
    assign w_dist     = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_hit      = w_dist <= {1'b0, r_sqr};
    assign w_last_pad = r_idx == PIW'(PAD_COUNT - 1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            HU_IDLE: begin
                if (i_start) begin
                    n_state = HU_MUL;
                end
            end
            HU_MUL: begin
                n_state = HU_CMP;
            end
            HU_CMP: begin
                if (w_hit || w_last_pad) begin
                    n_state = HU_IDLE;
                end else begin
                    n_state = HU_MUL;
                end
            end
            default: begin
                n_state = HU_IDLE;
            end
        endcase
    end

    // Response to the sequencer.
    always_comb begin
        o_rsp      = '0;
        o_rsp.pad  = w_hit ? PAD_IDX_W'(r_idx) : NO_PAD;
        o_rsp.note = w_pad.note;
        case (r_state)
            HU_CMP: begin
                o_rsp.done = w_hit || w_last_pad;
            end
            default: begin
                o_rsp.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HU_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == HU_IDLE) begin
                r_idx <= '0;
            end else if (r_state == HU_CMP && !w_hit && !w_last_pad) begin
                r_idx <= r_idx + PIW'(1);
            end
        end
    end

    // Touch point and squares need no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == HU_IDLE && i_start) begin
            r_x <= i_x;
            r_y <= i_y;
        end
        if (r_state == HU_MUL) begin
            r_sqx <= w_sqx;
            r_sqy <= w_sqy;
            r_sqr <= w_sqr;
        end
    end

endmodule

// ===== src/touch_drum_trigger_voice_table.sv =====
// Drum trigger top level: pad registers, finger map, sequencer, voice chain.
// A direct note goes to play, through a steal first when the table is full; a down or
// move walks the pads in order until the first hit. One item is in work at a time.
// Tick and release all emit one note-off per cycle while the output is not stalled.
// Synchronous active-low reset clears pads, finger map, count and tick clock.
module touch_drum_trigger_voice_table #(
    parameter int VOICE_SLOTS  = tdt_pkg::DEF_VOICE_SLOTS,
    parameter int FINGER_COUNT = tdt_pkg::DEF_FINGER_COUNT,
    parameter int PAD_COUNT    = tdt_pkg::DEF_PAD_COUNT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tdt_pkg::t_in                       i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tdt_pkg::t_out                      o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tdt_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tdt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tdt_pkg::*;

`include "touch_drum_trigger_voice_table_macros.svh"

    localparam int CW = $clog2(VOICE_SLOTS + 1);
    localparam int IW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam logic [RES_W-1:0] RES_LAST = RES_W'(MAX_RESULTS - 1);

    t_state               r_state;
    t_state               n_state;
    logic [CW-1:0]        r_count;
    logic [31:0]          r_tick;
    logic [PAD_IDX_W-1:0] r_map [FINGER_COUNT];
    t_pad                 r_pads [PAD_COUNT];
    logic [RES_W-1:0]     r_res;
    logic                 r_out_valid;
    t_out                 r_out;
    logic [2:0]           r_finger;
    logic [6:0]           r_vel;
    logic [6:0]           r_note;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_finger_ok;
    logic                 w_full;
    logic [6:0]           w_vel;
    logic [PAD_IDX_W-1:0] w_map_cur;
    t_hit_rsp             w_rsp;
    logic                 w_hit_start;
    logic                 w_emit;
    t_out                 w_out;
    logic                 w_rm;
    logic [IW-1:0]        w_rm_idx;
    logic                 w_app;

    t_voice               w_voice [VOICE_SLOTS];
    t_voice               w_load;
    logic [VOICE_SLOTS-1:0] w_cell_due;
    logic [VOICE_SLOTS-1:0] w_due;
    logic [IW-1:0]        w_first;
    logic [6:0]           w_first_note;
    logic                 w_any_due;
    logic                 w_more_due;

    // Handshake terms.
    assign o_in_ready  = r_state == ST_IDLE;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Finger range, table full and velocity of the incoming item.
    assign w_finger_ok = (FINGER_COUNT >= 8) || (i_in.finger < 3'(FINGER_COUNT));
    assign w_full      = r_count == CW'(VOICE_SLOTS);
    assign w_vel       = (i_in.pressure == 8'd0) ? DEFAULT_VELOCITY :
                         (i_in.pressure[7] ? VELOCITY_MAX : i_in.pressure[6:0]);

    // Pad remembered for the finger in work.
    always_comb begin
        w_map_cur = NO_PAD;
        for (int f = 0; f < FINGER_COUNT; f++) begin
            if (r_finger == 3'(f)) begin
                w_map_cur = r_map[f];
            end
        end
    end

    tdt_hit_unit #(
        .PAD_COUNT (PAD_COUNT)
    ) u_hit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hit_start),
        .i_x     (i_in.touch_x),
        .i_y     (i_in.touch_y),
        .i_pads  (r_pads),
        .o_rsp   (w_rsp)
    );

    // Row of voice cells; each closes up from its upper neighbour.
    assign w_load = '{note: r_note, rtime: r_tick + HOLD_TICKS};

    for (genvar i = 0; i < VOICE_SLOTS; i++) begin : g_cell
        t_cell_ctrl w_ctrl;
        t_voice     w_next;

        assign w_ctrl.shift = w_rm && (IW'(i) >= w_rm_idx);
        assign w_ctrl.load  = w_app && (r_count == CW'(i));
        assign w_next       = (i == VOICE_SLOTS - 1) ? w_load : w_voice[(i + 1) % VOICE_SLOTS];
        assign w_due[i]     = w_cell_due[i] && (CW'(i) < r_count);

        tdt_voice_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_next  (w_next),
            .i_load  (w_load),
            .i_tick  (r_tick),
            .o_voice (w_voice[i]),
            .o_due   (w_cell_due[i])
        );
    end

    // Oldest due note, and whether another stays due behind it.
    always_comb begin
        w_first = '0;
        for (int i = VOICE_SLOTS - 1; i >= 0; i--) begin
            if (w_due[i]) begin
                w_first = IW'(i);
            end
        end
    end

    always_comb begin
        w_first_note = w_voice[0].note;
        for (int i = 0; i < VOICE_SLOTS; i++) begin
            if (w_first == IW'(i)) begin
                w_first_note = w_voice[i].note;
            end
        end
    end

    assign w_any_due  = |w_due;
    assign w_more_due = |(w_due & (w_due - VOICE_SLOTS'(1)));

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.cmd)
                        CMD_DOWN, CMD_MOVE: begin
                            n_state = w_finger_ok ? ST_SEARCH : ST_IDLE;
                        end
                        CMD_DIRECT: begin
                            n_state = w_full ? ST_STEAL : ST_PLAY;
                        end
                        CMD_TICK: begin
                            n_state = ST_EXPIRE;
                        end
                        CMD_RELEASE: begin
                            n_state = ST_FLUSH;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (w_rsp.done) begin
                    if (w_rsp.pad != w_map_cur && w_rsp.pad != NO_PAD) begin
                        n_state = w_full ? ST_STEAL : ST_PLAY;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_STEAL: begin
                if (w_out_free) begin
                    n_state = ST_PLAY;
                end
            end
            ST_PLAY: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EXPIRE: begin
                if (!w_any_due || (w_emit && w_out.last)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (r_count == '0 || (w_emit && w_out.last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: results, chain control and hit test start.
    always_comb begin
        w_hit_start = 1'b0;
        w_emit      = 1'b0;
        w_out       = '0;
        w_rm        = 1'b0;
        w_rm_idx    = '0;
        w_app       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_hit_start = w_in_acc && w_finger_ok &&
                              (i_in.cmd == CMD_DOWN || i_in.cmd == CMD_MOVE);
            end
            ST_STEAL: begin
                w_out.note_number = w_voice[0].note;
                if (w_out_free) begin
                    w_emit = 1'b1;
                    w_rm   = 1'b1;
                end
            end
            ST_PLAY: begin
                w_out.note_on     = 1'b1;
                w_out.note_number = r_note;
                w_out.velocity    = r_vel;
                w_out.last        = 1'b1;
                if (w_out_free) begin
                    w_emit = 1'b1;
                    w_app  = 1'b1;
                end
            end
            ST_EXPIRE: begin
                w_out.note_number = w_first_note;
                w_out.last        = (r_res == RES_LAST) || !w_more_due;
                w_rm_idx          = w_first;
                if (w_out_free && w_any_due) begin
                    w_emit = 1'b1;
                    w_rm   = 1'b1;
                end
            end
            ST_FLUSH: begin
                w_out.note_number = w_voice[0].note;
                w_out.last        = (r_res == RES_LAST) || (r_count == CW'(1));
                if (w_out_free && r_count != '0) begin
                    w_emit = 1'b1;
                    w_rm   = 1'b1;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Control state, pad registers and finger map.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_tick      <= '0;
            r_res       <= '0;
            r_out_valid <= 1'b0;
            for (int f = 0; f < FINGER_COUNT; f++) begin
                r_map[f] <= NO_PAD;
            end
            for (int p = 0; p < PAD_COUNT; p++) begin
                r_pads[p] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (w_rm) begin
                r_count <= r_count - CW'(1);
            end else if (w_app) begin
                r_count <= r_count + CW'(1);
            end

            if (w_in_acc && i_in.cmd == CMD_TICK) begin
                r_tick <= r_tick + 32'd1;
            end

            if (w_in_acc) begin
                r_res <= '0;
            end else if (w_emit) begin
                r_res <= r_res + RES_W'(1);
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // An up clears the pad; a finished search stores the new one.
            for (int f = 0; f < FINGER_COUNT; f++) begin
                if (w_in_acc && i_in.cmd == CMD_UP && i_in.finger == 3'(f)) begin
                    r_map[f] <= NO_PAD;
                end else if (r_state == ST_SEARCH && w_rsp.done &&
                             r_finger == 3'(f)) begin
                    r_map[f] <= w_rsp.pad;
                end
            end

            // Writes to registers beyond the pad count are dropped.
            for (int p = 0; p < PAD_COUNT; p++) begin
                if (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_INDEX_W'(p)) begin
                    r_pads[p] <= t_pad'(i_cfg_data);
                end
            end
        end
    end

    // Item fields and the result register need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_finger <= i_in.finger;
            r_vel    <= w_vel;
            r_note   <= i_in.direct_note;
        end else if (r_state == ST_SEARCH && w_rsp.done) begin
            r_note <= w_rsp.note;
        end
        if (w_emit) begin
            r_out <= w_out;
        end
    end

    // A note-on always closes the results of its item.
    `TDT_ASSERT_NOW(a_note_on_last, i_clk, i_rst_n, o_out_valid && o_out.note_on,
        o_out.last, "note-on result not marked last")

    // A note-on is only placed when the table has room for it.
    `TDT_ASSERT_NOW(a_room_for_note, i_clk, i_rst_n, w_app,
        r_count < CW'(VOICE_SLOTS), "note-on placed into a full voice table")

    // A tick advances the clock by exactly one.
    `TDT_ASSERT_NEXT(a_tick_step, i_clk, i_rst_n, w_in_acc && i_in.cmd == CMD_TICK,
        r_tick == $past(r_tick) + 32'd1, "tick clock did not advance by one")

endmodule
